@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL of the two-class priority queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// A condition that, when true, must be followed in the same cycle by another.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A condition that, when true, must be followed in the next cycle by another.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/tcpq_pkg.sv @@
// Package of constants, codes and entry types for the two-class priority queue.
`timescale 1ns / 1ps

package tcpq_pkg;

    localparam int URG_DEPTH = 16;
    localparam int REG_DEPTH = 16;
    localparam int ID_BITS   = 16;

    localparam int URG_AW    = $clog2(URG_DEPTH);
    localparam int REG_AW    = $clog2(REG_DEPTH);
    localparam int URG_CNT_W = $clog2(URG_DEPTH + 1);
    localparam int REG_CNT_W = $clog2(REG_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_ADD_URG = 2'd0,
        KIND_ADD_REG = 2'd1,
        KIND_SERVE   = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_ADDED   = 3'd0,
        ST_FULL    = 3'd1,
        ST_SRV_URG = 3'd2,
        ST_SRV_REG = 3'd3,
        ST_EMPTY   = 3'd4
    } t_status;

    typedef struct packed {
        logic [ID_BITS-1:0] id;
        logic [15:0]        tag;
        logic [3:0]         sev;
    } t_urg_entry;

    typedef struct packed {
        logic [ID_BITS-1:0] id;
        logic [15:0]        tag;
    } t_reg_entry;

endpackage

@@ hw/rtl/tcpq_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module tcpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/two_class_priority_queue.sv @@
// Each request ends in S_DONE, after S_R_HEAD for a regular serve, S_U_INS for an urgent
// add and S_U_HEAD, S_U_SHIFT for an urgent serve; the urgent store is shifted one entry a
// cycle through its RAM port, and S_U_SHIFT is skipped when a serve empties the store.
// One request is in work at a time; the next is accepted once the result has moved into
// the output register. Reset clears both counts, the FIFO head and the result valid flag
// and sets the sequence to one; the store RAMs are not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module two_class_priority_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_tag,
    input  logic [3:0]  i_severity,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [15:0] o_entry_id,
    output logic [15:0] o_entry_tag,
    output logic [3:0]  o_entry_severity,
    output logic [4:0]  o_urgent_count,
    output logic [4:0]  o_regular_count
);

    import tcpq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_U_INS,
        S_U_HEAD,
        S_U_SHIFT,
        S_R_HEAD,
        S_DONE
    } t_state;

    // Control state
    t_state                r_state, n_state;
    logic [URG_CNT_W-1:0]  r_ucnt, n_ucnt;
    logic [REG_CNT_W-1:0]  r_rcnt, n_rcnt;
    logic [REG_AW-1:0]     r_rhead, n_rhead;
    logic [ID_BITS-1:0]    r_seq, n_seq;
    logic                  r_out_valid, n_out_valid;

    // Request and result payload
    logic [15:0]           r_tag, n_tag;
    logic [3:0]            r_sev, n_sev;
    logic [ID_BITS-1:0]    r_id, n_id;
    logic [URG_CNT_W-1:0]  r_idx, n_idx;
    t_status               r_res_status, n_res_status;
    logic [ID_BITS-1:0]    r_res_id, n_res_id;
    logic [15:0]           r_res_tag, n_res_tag;
    logic [3:0]            r_res_sev, n_res_sev;
    t_status               r_o_status, n_o_status;
    logic [15:0]           r_o_id, n_o_id;
    logic [15:0]           r_o_tag, n_o_tag;
    logic [3:0]            r_o_sev, n_o_sev;
    logic [4:0]            r_o_ucnt, n_o_ucnt;
    logic [4:0]            r_o_rcnt, n_o_rcnt;

    // RAM ports
    logic                  u_we;
    logic [URG_AW-1:0]     u_waddr, u_raddr;
    t_urg_entry            u_wdata, u_rdata;
    logic                  g_we;
    logic [REG_AW-1:0]     g_waddr, g_raddr;
    t_reg_entry            g_wdata, g_rdata;

    logic [REG_CNT_W:0]    reg_sum;
    logic [REG_AW-1:0]     reg_tail;
    logic                  in_acc;

    tcpq_ram #(
        .WIDTH ($bits(t_urg_entry)),
        .DEPTH (URG_DEPTH)
    ) u_urg_ram (
        .i_clk   (i_clk),
        .i_we    (u_we),
        .i_waddr (u_waddr),
        .i_wdata (u_wdata),
        .i_raddr (u_raddr),
        .o_rdata (u_rdata)
    );

    tcpq_ram #(
        .WIDTH ($bits(t_reg_entry)),
        .DEPTH (REG_DEPTH)
    ) u_reg_ram (
        .i_clk   (i_clk),
        .i_we    (g_we),
        .i_waddr (g_waddr),
        .i_wdata (g_wdata),
        .i_raddr (g_raddr),
        .o_rdata (g_rdata)
    );

    assign in_acc  = i_in_valid && o_in_ready;
    assign reg_sum = (REG_CNT_W + 1)'(r_rhead) + (REG_CNT_W + 1)'(r_rcnt);
    assign reg_tail = (reg_sum >= (REG_CNT_W + 1)'(REG_DEPTH))
                    ? REG_AW'(reg_sum - (REG_CNT_W + 1)'(REG_DEPTH))
                    : REG_AW'(reg_sum);

    always_comb begin
        n_state      = r_state;
        n_ucnt       = r_ucnt;
        n_rcnt       = r_rcnt;
        n_rhead      = r_rhead;
        n_seq        = r_seq;
        n_out_valid  = r_out_valid;
        n_tag        = r_tag;
        n_sev        = r_sev;
        n_id         = r_id;
        n_idx        = r_idx;
        n_res_status = r_res_status;
        n_res_id     = r_res_id;
        n_res_tag    = r_res_tag;
        n_res_sev    = r_res_sev;
        n_o_status   = r_o_status;
        n_o_id       = r_o_id;
        n_o_tag      = r_o_tag;
        n_o_sev      = r_o_sev;
        n_o_ucnt     = r_o_ucnt;
        n_o_rcnt     = r_o_rcnt;

        u_we    = 1'b0;
        u_waddr = URG_AW'(r_idx);
        u_wdata = '{id: r_id, tag: r_tag, sev: r_sev};
        u_raddr = '0;
        g_we    = 1'b0;
        g_waddr = reg_tail;
        g_wdata = '{id: r_seq, tag: i_tag};
        g_raddr = r_rhead;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_tag        = i_tag;
                    n_sev        = i_severity;
                    n_res_id     = '0;
                    n_res_tag    = '0;
                    n_res_sev    = '0;
                    n_res_status = ST_EMPTY;
                    n_state      = S_DONE;
                    case (t_kind'(i_kind))
                        KIND_ADD_URG: begin
                            if (r_ucnt == URG_CNT_W'(URG_DEPTH)) begin
                                n_res_status = ST_FULL;
                            end else begin
                                n_res_status = ST_ADDED;
                                n_res_id     = r_seq;
                                n_id         = r_seq;
                                n_seq        = r_seq + ID_BITS'(1);
                                n_ucnt       = r_ucnt + URG_CNT_W'(1);
                                // Walk from the tail towards the head, shifting lower
                                // severities back by one until the insert point is found.
                                n_idx        = r_ucnt;
                                u_raddr      = URG_AW'(r_ucnt - URG_CNT_W'(1));
                                n_state      = S_U_INS;
                            end
                        end
                        KIND_ADD_REG: begin
                            if (r_rcnt == REG_CNT_W'(REG_DEPTH)) begin
                                n_res_status = ST_FULL;
                            end else begin
                                g_we         = 1'b1;
                                n_res_status = ST_ADDED;
                                n_res_id     = r_seq;
                                n_seq        = r_seq + ID_BITS'(1);
                                n_rcnt       = r_rcnt + REG_CNT_W'(1);
                            end
                        end
                        KIND_SERVE: begin
                            if (r_ucnt != '0) begin
                                u_raddr = '0;
                                n_state = S_U_HEAD;
                            end else if (r_rcnt != '0) begin
                                g_raddr = r_rhead;
                                n_state = S_R_HEAD;
                            end
                        end
                        default: begin
                            n_res_status = ST_EMPTY;
                        end
                    endcase
                end
            end
            S_U_INS: begin
                u_we = 1'b1;
                if (r_idx == '0 || u_rdata.sev >= r_sev) begin
                    n_state = S_DONE;
                end else begin
                    u_wdata = u_rdata;
                    n_idx   = r_idx - URG_CNT_W'(1);
                    u_raddr = URG_AW'(r_idx - URG_CNT_W'(2));
                end
            end
            S_U_HEAD: begin
                n_res_status = ST_SRV_URG;
                n_res_id     = u_rdata.id;
                n_res_tag    = u_rdata.tag;
                n_res_sev    = u_rdata.sev;
                n_ucnt       = r_ucnt - URG_CNT_W'(1);
                if (r_ucnt == URG_CNT_W'(1)) begin
                    n_state = S_DONE;
                end else begin
                    n_idx   = URG_CNT_W'(1);
                    u_raddr = URG_AW'(1);
                    n_state = S_U_SHIFT;
                end
            end
            S_U_SHIFT: begin
                // The count is already reduced, so the last entry to move sits at r_ucnt.
                u_we    = 1'b1;
                u_waddr = URG_AW'(r_idx - URG_CNT_W'(1));
                u_wdata = u_rdata;
                if (r_idx == r_ucnt) begin
                    n_state = S_DONE;
                end else begin
                    n_idx   = r_idx + URG_CNT_W'(1);
                    u_raddr = URG_AW'(r_idx + URG_CNT_W'(1));
                end
            end
            S_R_HEAD: begin
                n_res_status = ST_SRV_REG;
                n_res_id     = g_rdata.id;
                n_res_tag    = g_rdata.tag;
                n_res_sev    = '0;
                n_rcnt       = r_rcnt - REG_CNT_W'(1);
                n_rhead      = (r_rhead == REG_AW'(REG_DEPTH - 1))
                             ? '0 : r_rhead + REG_AW'(1);
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_o_status  = r_res_status;
                    n_o_id      = 16'(r_res_id);
                    n_o_tag     = r_res_tag;
                    n_o_sev     = r_res_sev;
                    n_o_ucnt    = 5'(r_ucnt);
                    n_o_rcnt    = 5'(r_rcnt);
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ucnt      <= '0;
            r_rcnt      <= '0;
            r_rhead     <= '0;
            r_seq       <= ID_BITS'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ucnt      <= n_ucnt;
            r_rcnt      <= n_rcnt;
            r_rhead     <= n_rhead;
            r_seq       <= n_seq;
            r_out_valid <= n_out_valid;
        end
        r_tag        <= n_tag;
        r_sev        <= n_sev;
        r_id         <= n_id;
        r_idx        <= n_idx;
        r_res_status <= n_res_status;
        r_res_id     <= n_res_id;
        r_res_tag    <= n_res_tag;
        r_res_sev    <= n_res_sev;
        r_o_status   <= n_o_status;
        r_o_id       <= n_o_id;
        r_o_tag      <= n_o_tag;
        r_o_sev      <= n_o_sev;
        r_o_ucnt     <= n_o_ucnt;
        r_o_rcnt     <= n_o_rcnt;
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_o_status;
    assign o_entry_id       = r_o_id;
    assign o_entry_tag      = r_o_tag;
    assign o_entry_severity = r_o_sev;
    assign o_urgent_count   = r_o_ucnt;
    assign o_regular_count  = r_o_rcnt;

    `ASSERT_ALWAYS(a_cnt_bound, (r_ucnt <= URG_CNT_W'(URG_DEPTH)) && (r_rcnt <= REG_CNT_W'(REG_DEPTH)), "store count exceeds its depth")
    `ASSERT_NEXT(a_busy_after_req, in_acc, !o_in_ready, "a second request was taken while one is in work")
    `ASSERT_IMPLY(a_seq_on_req, !$stable(r_seq), $past(in_acc), "sequence moved without a request")
    `ASSERT_IMPLY(a_no_entry_fields, o_out_valid && (o_status == ST_FULL || o_status == ST_EMPTY), (o_entry_id == '0) && (o_entry_tag == '0) && (o_entry_severity == '0), "reject or empty result carries entry fields")

endmodule
